@@ design/pto_pkg.sv @@
// ----------------------------------------------------------------------------
// pto_pkg: shared types and constants for the price-time order matcher
// Request and result layouts, codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pto_pkg;

   localparam int ORDER_SLOTS = 32;
   localparam int SLOT_IDX_W  = $clog2(ORDER_SLOTS);
   localparam int SUM_W       = 32 + SLOT_IDX_W;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_MODIFY = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OT_GTC    = 2'd0,
      OT_FAK    = 2'd1,
      OT_FOK    = 2'd2,
      OT_MARKET = 2'd3
   } order_kind_type;

   typedef enum logic [1:0] {
      STP_NONE        = 2'd0,
      STP_CANCEL_AGG  = 2'd1,
      STP_CANCEL_PAS  = 2'd2,
      STP_CANCEL_BOTH = 2'd3
   } stp_type;

   typedef enum logic [3:0] {
      RK_TRADE     = 4'd0,
      RK_RESTED    = 4'd1,
      RK_DONE      = 4'd2,
      RK_DUPLICATE = 4'd3,
      RK_FOK_REJ   = 4'd4,
      RK_FAK_REJ   = 4'd5,
      RK_CANCELLED = 4'd6,
      RK_UNKNOWN   = 4'd7,
      RK_MODIFIED  = 4'd8,
      RK_STP_STOP  = 4'd9,
      RK_BOOK_FULL = 4'd10
   } result_kind_type;

   typedef struct packed {
      mode_type           mode;
      logic [31:0]        order_id;
      logic [15:0]        trader_id;
      logic               side;
      order_kind_type     order_type;
      stp_type            stp_action;
      logic signed [31:0] price;
      logic [31:0]        quantity;
   } req_type;

   typedef struct packed {
      result_kind_type    result_kind;
      logic [31:0]        aggressor_id;
      logic [31:0]        resting_id;
      logic signed [31:0] aggressor_price;
      logic signed [31:0] resting_price;
      logic [31:0]        trade_quantity;
      logic               last_result;
   } rsp_type;

   typedef enum logic [1:0] {
      SCAN_ID   = 2'd0,
      SCAN_BEST = 2'd1,
      SCAN_SUM  = 2'd2,
      SCAN_FREE = 2'd3
   } scan_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_FILL    = 3'd1,
      ACT_REMOVE  = 3'd2,
      ACT_SET_QTY = 3'd3,
      ACT_READD   = 3'd4,
      ACT_REST    = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_ID,
      ST_ID_DONE,
      ST_SCAN_SUM,
      ST_SUM_DONE,
      ST_SCAN_ANY,
      ST_ANY_DONE,
      ST_LOOP,
      ST_SCAN_BEST,
      ST_BEST_DONE,
      ST_END,
      ST_SCAN_FREE,
      ST_FREE_DONE
   } state_type;

   typedef struct packed {
      logic            scan_clear;
      logic            scan_on;
      scan_type        scan_kind;
      logic            emit;
      result_kind_type emit_kind;
      logic            emit_last;
      action_type      action;
   } cmd_type;

   typedef struct packed {
      logic           scan_last;
      logic           out_free;
      logic           hit;
      mode_type       mode;
      order_kind_type otype;
      stp_type        stp;
      logic           stp_hit;
      logic           qty_zero;
      logic           rem_zero;
      logic           sum_short;
      logic           mod_keep;
   } status_type;

endpackage

@@ design/pto_ctrl.sv @@
// ----------------------------------------------------------------------------
// pto_ctrl: request sequencer
// Steps each request through slot scans, match decisions and result issue.
// ----------------------------------------------------------------------------
module pto_ctrl import pto_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.scan_clear = 1'b0;
      cmd.scan_on    = 1'b0;
      cmd.scan_kind  = SCAN_ID;
      cmd.emit       = 1'b0;
      cmd.emit_kind  = RK_DONE;
      cmd.emit_last  = 1'b1;
      cmd.action     = ACT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in       = ST_SCAN_ID;
               cmd.scan_clear = 1'b1;
            end
         end
         ST_SCAN_ID: begin
            cmd.scan_on   = 1'b1;
            cmd.scan_kind = SCAN_ID;
            if (status.scan_last) state_in = ST_ID_DONE;
         end
         ST_ID_DONE: begin
            case (status.mode)
               MODE_ADD: begin
                  if (status.hit) begin
                     if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = RK_DUPLICATE;
                        state_in      = ST_IDLE;
                     end
                  end else if (status.otype == OT_FOK) begin
                     state_in       = ST_SCAN_SUM;
                     cmd.scan_clear = 1'b1;
                  end else if (status.otype == OT_FAK) begin
                     state_in       = ST_SCAN_ANY;
                     cmd.scan_clear = 1'b1;
                  end else begin
                     state_in = ST_LOOP;
                  end
               end
               MODE_CANCEL: begin
                  if (status.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                     if (status.hit) begin
                        cmd.emit_kind = RK_CANCELLED;
                        cmd.action    = ACT_REMOVE;
                     end else begin
                        cmd.emit_kind = RK_UNKNOWN;
                     end
                  end
               end
               MODE_MODIFY: begin
                  if (status.hit && !status.qty_zero && !status.mod_keep) begin
                     // cancel and add again, keeping stored trader and stp
                     cmd.action = ACT_READD;
                     state_in   = ST_LOOP;
                  end else if (status.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                     if (!status.hit) begin
                        cmd.emit_kind = RK_UNKNOWN;
                     end else if (status.qty_zero) begin
                        cmd.emit_kind = RK_CANCELLED;
                        cmd.action    = ACT_REMOVE;
                     end else begin
                        cmd.emit_kind = RK_MODIFIED;
                        cmd.action    = ACT_SET_QTY;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN_SUM: begin
            cmd.scan_on   = 1'b1;
            cmd.scan_kind = SCAN_SUM;
            if (status.scan_last) state_in = ST_SUM_DONE;
         end
         ST_SUM_DONE: begin
            if (!status.sum_short) begin
               state_in = ST_LOOP;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = RK_FOK_REJ;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN_ANY: begin
            cmd.scan_on   = 1'b1;
            cmd.scan_kind = SCAN_BEST;
            if (status.scan_last) state_in = ST_ANY_DONE;
         end
         ST_ANY_DONE: begin
            if (status.hit) begin
               state_in = ST_LOOP;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = RK_FAK_REJ;
               state_in      = ST_IDLE;
            end
         end
         ST_LOOP: begin
            if (status.rem_zero) begin
               state_in = ST_END;
            end else begin
               state_in       = ST_SCAN_BEST;
               cmd.scan_clear = 1'b1;
            end
         end
         ST_SCAN_BEST: begin
            cmd.scan_on   = 1'b1;
            cmd.scan_kind = SCAN_BEST;
            if (status.scan_last) state_in = ST_BEST_DONE;
         end
         ST_BEST_DONE: begin
            if (!status.hit) begin
               state_in = ST_END;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.stp_hit) begin
                  cmd.emit_kind = RK_STP_STOP;
                  case (status.stp)
                     STP_CANCEL_AGG: begin
                        state_in = ST_IDLE;
                     end
                     STP_CANCEL_BOTH: begin
                        cmd.action = ACT_REMOVE;
                        state_in   = ST_IDLE;
                     end
                     default: begin
                        // cancel passive: drop the resting order and go on
                        cmd.action    = ACT_REMOVE;
                        cmd.emit_last = 1'b0;
                        state_in      = ST_LOOP;
                     end
                  endcase
               end else begin
                  cmd.emit_kind = RK_TRADE;
                  cmd.emit_last = 1'b0;
                  cmd.action    = ACT_FILL;
                  state_in      = ST_LOOP;
               end
            end
         end
         ST_END: begin
            if (status.otype == OT_GTC && !status.rem_zero) begin
               state_in       = ST_SCAN_FREE;
               cmd.scan_clear = 1'b1;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = RK_DONE;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN_FREE: begin
            cmd.scan_on   = 1'b1;
            cmd.scan_kind = SCAN_FREE;
            if (status.scan_last) state_in = ST_FREE_DONE;
         end
         ST_FREE_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
               if (status.hit) begin
                  cmd.emit_kind = RK_RESTED;
                  cmd.action    = ACT_REST;
               end else begin
                  cmd.emit_kind = RK_BOOK_FULL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/pto_datapath.sv @@
// ----------------------------------------------------------------------------
// pto_datapath: order slots, scan unit and result register
// Scans one slot a cycle, keeps the selected slot, applies fills and writes.
// ----------------------------------------------------------------------------
module pto_datapath import pto_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_accept,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  cmd_type    cmd,
   output status_type status
);

   // slot store
   logic [ORDER_SLOTS-1:0] slot_valid_ff;
   logic [31:0]            slot_id_ff      [ORDER_SLOTS];
   logic [15:0]            slot_trader_ff  [ORDER_SLOTS];
   logic                   slot_side_ff    [ORDER_SLOTS];
   logic signed [31:0]     slot_price_ff   [ORDER_SLOTS];
   logic [31:0]            slot_rem_ff     [ORDER_SLOTS];
   stp_type                slot_stp_ff     [ORDER_SLOTS];
   logic [31:0]            slot_arrival_ff [ORDER_SLOTS];
   logic [31:0]            arrival_ff;

   // working request
   req_type        req_ff;
   logic [31:0]    rem_ff, rem_in;
   logic [15:0]    trader_ff;
   stp_type        stp_ff;
   order_kind_type otype_ff;

   // scan state
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  hit_ff, hit_in;
   logic [SLOT_IDX_W-1:0] hit_idx_ff;
   logic [31:0]           hit_id_ff;
   logic signed [31:0]    hit_price_ff;
   logic [31:0]           hit_rem_ff;
   logic [15:0]           hit_trader_ff;
   stp_type               hit_stp_ff;
   logic [31:0]           hit_age_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  cur_valid, cur_side, elig, better, take;
   logic signed [31:0]    cur_price;
   logic [31:0]           cur_age, fill_q, fill_left;

   // look at the slot under the scan index
   always_comb begin
      cur_valid = slot_valid_ff[idx_ff];
      cur_side  = slot_side_ff[idx_ff];
      cur_price = slot_price_ff[idx_ff];
      cur_age   = arrival_ff - slot_arrival_ff[idx_ff];
      elig      = cur_valid && (cur_side != req_ff.side) &&
                  ((otype_ff == OT_MARKET) ||
                   (req_ff.side ? (cur_price >= req_ff.price)
                                : (cur_price <= req_ff.price)));
      if (cur_price != hit_price_ff) begin
         better = req_ff.side ? (cur_price > hit_price_ff) : (cur_price < hit_price_ff);
      end else begin
         better = cur_age > hit_age_ff;
      end
      case (cmd.scan_kind)
         SCAN_ID:   take = !hit_ff && cur_valid && (slot_id_ff[idx_ff] == req_ff.order_id);
         SCAN_BEST: take = elig && (!hit_ff || better);
         SCAN_FREE: take = !hit_ff && !cur_valid;
         default:   take = 1'b0;
      endcase
      take = take && cmd.scan_on;
   end

   // scan index, hit flag and eligible sum
   always_comb begin
      idx_in = idx_ff;
      hit_in = hit_ff;
      sum_in = sum_ff;
      if (cmd.scan_clear) begin
         idx_in = '0;
         hit_in = 1'b0;
         sum_in = '0;
      end else if (cmd.scan_on) begin
         idx_in = idx_ff + 1'b1;
         if (take) hit_in = 1'b1;
         if (cmd.scan_kind == SCAN_SUM && elig) begin
            sum_in = sum_ff + SUM_W'(slot_rem_ff[idx_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      if (take) begin
         hit_idx_ff    <= idx_ff;
         hit_id_ff     <= slot_id_ff[idx_ff];
         hit_price_ff  <= cur_price;
         hit_rem_ff    <= slot_rem_ff[idx_ff];
         hit_trader_ff <= slot_trader_ff[idx_ff];
         hit_stp_ff    <= slot_stp_ff[idx_ff];
         hit_age_ff    <= cur_age;
      end
   end

   // fill size against the selected resting order
   always_comb begin
      fill_q    = (rem_ff < hit_rem_ff) ? rem_ff : hit_rem_ff;
      fill_left = hit_rem_ff - fill_q;
      rem_in    = rem_ff;
      if (req_accept) begin
         rem_in = req_data.quantity;
      end else if (cmd.action == ACT_FILL) begin
         rem_in = rem_ff - fill_q;
      end
   end

   // latch the request and apply re-add overrides
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (req_accept) begin
         req_ff    <= req_data;
         trader_ff <= req_data.trader_id;
         stp_ff    <= req_data.stp_action;
         otype_ff  <= req_data.order_type;
      end else if (cmd.action == ACT_READD) begin
         trader_ff <= hit_trader_ff;
         stp_ff    <= hit_stp_ff;
         otype_ff  <= OT_GTC;
      end
   end

   // slot updates
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         arrival_ff    <= '0;
      end else begin
         case (cmd.action)
            ACT_FILL: begin
               if (fill_left == 32'd0) slot_valid_ff[hit_idx_ff] <= 1'b0;
            end
            ACT_REMOVE, ACT_READD: begin
               slot_valid_ff[hit_idx_ff] <= 1'b0;
            end
            ACT_REST: begin
               slot_valid_ff[hit_idx_ff] <= 1'b1;
               arrival_ff                <= arrival_ff + 32'd1;
            end
            default: begin
            end
         endcase
      end
      case (cmd.action)
         ACT_FILL: begin
            slot_rem_ff[hit_idx_ff] <= fill_left;
         end
         ACT_SET_QTY: begin
            slot_rem_ff[hit_idx_ff] <= req_ff.quantity;
         end
         ACT_REST: begin
            slot_id_ff[hit_idx_ff]      <= req_ff.order_id;
            slot_trader_ff[hit_idx_ff]  <= trader_ff;
            slot_side_ff[hit_idx_ff]    <= req_ff.side;
            slot_price_ff[hit_idx_ff]   <= req_ff.price;
            slot_rem_ff[hit_idx_ff]     <= rem_ff;
            slot_stp_ff[hit_idx_ff]     <= stp_ff;
            slot_arrival_ff[hit_idx_ff] <= arrival_ff;
         end
         default: begin
         end
      endcase
   end

   // build the result for the issued kind
   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_in.result_kind     = cmd.emit_kind;
      rsp_in.aggressor_id    = req_ff.order_id;
      rsp_in.aggressor_price = req_ff.price;
      rsp_in.resting_id      = '0;
      rsp_in.resting_price   = '0;
      rsp_in.trade_quantity  = '0;
      rsp_in.last_result     = cmd.emit_last;
      case (cmd.emit_kind)
         RK_TRADE: begin
            rsp_in.resting_id     = hit_id_ff;
            rsp_in.resting_price  = hit_price_ff;
            rsp_in.trade_quantity = fill_q;
         end
         RK_STP_STOP: begin
            rsp_in.resting_id     = hit_id_ff;
            rsp_in.resting_price  = hit_price_ff;
            rsp_in.trade_quantity = cmd.emit_last ? rem_ff : 32'd0;
         end
         RK_RESTED, RK_DONE, RK_BOOK_FULL: begin
            rsp_in.trade_quantity = rem_ff;
         end
         RK_FOK_REJ, RK_FAK_REJ, RK_MODIFIED: begin
            rsp_in.trade_quantity = req_ff.quantity;
         end
         RK_CANCELLED: begin
            rsp_in.trade_quantity = hit_rem_ff;
         end
         default: begin
         end
      endcase
   end

   // result register: load on issue, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the sequencer
   always_comb begin
      status.scan_last = (idx_ff == SLOT_IDX_W'(ORDER_SLOTS - 1));
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.hit       = hit_ff;
      status.mode      = req_ff.mode;
      status.otype     = otype_ff;
      status.stp       = stp_ff;
      status.stp_hit   = (hit_trader_ff == trader_ff) && (stp_ff != STP_NONE);
      status.qty_zero  = (req_ff.quantity == 32'd0);
      status.rem_zero  = (rem_ff == 32'd0);
      status.sum_short = (sum_ff < SUM_W'(req_ff.quantity));
      status.mod_keep  = (hit_price_ff == req_ff.price) && (hit_rem_ff >= req_ff.quantity);
   end

endmodule

@@ design/price_time_order_matcher.sv @@
// ----------------------------------------------------------------------------
// price_time_order_matcher: price-time priority order book with bounded slots
// Each slot scan walks the ORDER_SLOTS entries one per cycle. Cancel, unknown
// id and in-place modify take one id scan. Add takes an id scan, a check scan
// for FOK or FAK, one best-price scan per fill and a free-slot scan to rest.
// One request in flight; the next is taken after its last result is issued.
// Synchronous reset empties the book and clears the arrival counter at once.
// ----------------------------------------------------------------------------
module price_time_order_matcher import pto_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;
   logic       req_accept;

   assign req_accept = req_valid && req_ready;

   // sequencer
   pto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slots, scan and result register
   pto_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the price-time order matcher
// Drives add, cancel and modify requests through the valid/ready channels,
// predicts the trade and status results in a local book copy, and compares
// every result field by field.
// ----------------------------------------------------------------------------
module testbench;
   import pto_pkg::*;

   localparam int NSLOT      = 32;
   localparam int IDLE_LIMIT = 20000;

   // Local copy of the book and the expected result store
   class book_scoreboard;
      bit          live[NSLOT];
      bit [31:0]   oid[NSLOT];
      bit [15:0]   trd[NSLOT];
      bit          sd[NSLOT];
      int          px[NSLOT];
      bit [31:0]   qty[NSLOT];
      stp_type     stp[NSLOT];
      bit [31:0]   arr[NSLOT];
      bit [31:0]   arr_count;
      rsp_type     pending[$];
      bit [31:0]   cur_id;
      int          cur_px;
      int          errors;
      int          n_trades;
      int          n_results;

      function void push(result_kind_type k, bit [31:0] rid, int rpx, bit [31:0] q, bit lst);
         rsp_type r;
         r.result_kind     = k;
         r.aggressor_id    = cur_id;
         r.resting_id      = rid;
         r.aggressor_price = cur_px;
         r.resting_price   = rpx;
         r.trade_quantity  = q;
         r.last_result     = lst;
         pending.insert(pending.size(), r);
      endfunction

      function int lookup(bit [31:0] id);
         for (int i = 0; i < NSLOT; i++)
            if (live[i] && oid[i] == id) return i;
         return -1;
      endfunction

      function bit can_hit(int i, bit s, order_kind_type t, int p);
         if (!live[i] || sd[i] == s) return 0;
         if (t == OT_MARKET) return 1;
         return (s == 1'b0) ? (px[i] <= p) : (px[i] >= p);
      endfunction

      function bit ahead(int a, int b, bit s);
         if (px[a] != px[b]) return (s == 1'b0) ? (px[a] < px[b]) : (px[a] > px[b]);
         return (arr_count - arr[a]) > (arr_count - arr[b]);
      endfunction

      function void place(bit [31:0] id, bit [15:0] tr, bit s, order_kind_type t, stp_type st,
                          int p, bit [31:0] q, bit dup_check);
         bit [31:0] rem;
         bit [63:0] total;
         bit        any;
         int        best;
         int        fr;
         bit [31:0] fill;
         rem = q;
         if (dup_check && lookup(id) >= 0) begin
            push(RK_DUPLICATE, 0, 0, 0, 1);
            return;
         end
         if (t == OT_FOK) begin
            total = 0;
            for (int i = 0; i < NSLOT; i++)
               if (can_hit(i, s, t, p)) total += qty[i];
            if (total < q) begin
               push(RK_FOK_REJ, 0, 0, q, 1);
               return;
            end
         end
         if (t == OT_FAK) begin
            any = 0;
            for (int i = 0; i < NSLOT; i++)
               if (can_hit(i, s, t, p)) any = 1;
            if (!any) begin
               push(RK_FAK_REJ, 0, 0, q, 1);
               return;
            end
         end
         while (rem != 0) begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
               if (can_hit(i, s, t, p) && (best < 0 || ahead(i, best, s))) best = i;
            if (best < 0) break;
            if (trd[best] == tr && st != STP_NONE) begin
               if (st == STP_CANCEL_AGG) begin
                  push(RK_STP_STOP, oid[best], px[best], rem, 1);
                  return;
               end
               live[best] = 0;
               if (st == STP_CANCEL_BOTH) begin
                  push(RK_STP_STOP, oid[best], px[best], rem, 1);
                  return;
               end
               push(RK_STP_STOP, oid[best], px[best], 0, 0);
               continue;
            end
            fill = (rem < qty[best]) ? rem : qty[best];
            rem -= fill;
            qty[best] -= fill;
            if (qty[best] == 0) live[best] = 0;
            push(RK_TRADE, oid[best], px[best], fill, 0);
         end
         if (t == OT_GTC && rem != 0) begin
            fr = -1;
            for (int i = 0; i < NSLOT; i++)
               if (!live[i] && fr < 0) fr = i;
            if (fr < 0) begin
               push(RK_BOOK_FULL, 0, 0, rem, 1);
               return;
            end
            live[fr] = 1; oid[fr] = id; trd[fr] = tr; sd[fr] = s; px[fr] = p;
            qty[fr] = rem; stp[fr] = st; arr[fr] = arr_count;
            arr_count++;
            push(RK_RESTED, 0, 0, rem, 1);
            return;
         end
         push(RK_DONE, 0, 0, rem, 1);
      endfunction

      // Note an accepted request and queue the results it causes
      function void note_request(req_type r);
         int s;
         cur_id = r.order_id;
         cur_px = r.price;
         case (r.mode)
            MODE_ADD: begin
               place(r.order_id, r.trader_id, r.side, r.order_type, r.stp_action, r.price,
                     r.quantity, 1);
            end
            MODE_CANCEL, MODE_MODIFY: begin
               s = lookup(r.order_id);
               if (s < 0) begin
                  push(RK_UNKNOWN, 0, 0, 0, 1);
               end else if (r.mode == MODE_CANCEL || r.quantity == 0) begin
                  live[s] = 0;
                  push(RK_CANCELLED, 0, 0, qty[s], 1);
               end else if (px[s] == r.price && qty[s] >= r.quantity) begin
                  qty[s] = r.quantity;
                  push(RK_MODIFIED, 0, 0, r.quantity, 1);
               end else begin
                  live[s] = 0;
                  place(r.order_id, trd[s], r.side, OT_GTC, stp[s], r.price, r.quantity, 0);
               end
            end
            default: begin
            end
         endcase
      endfunction

      // Compare one result with the oldest expectation
      function void check_result(rsp_type a);
         rsp_type e;
         n_results++;
         if (pending.size() == 0) begin
            $error("result with nothing expected: kind %0d id %0h", a.result_kind,
                   a.aggressor_id);
            errors++;
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (e.result_kind == RK_TRADE) n_trades++;
         if (a.result_kind != e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind); errors++;
         end
         if (a.aggressor_id != e.aggressor_id) begin
            $error("aggressor_id exp %0h got %0h", e.aggressor_id, a.aggressor_id); errors++;
         end
         if (a.resting_id != e.resting_id) begin
            $error("resting_id exp %0h got %0h", e.resting_id, a.resting_id); errors++;
         end
         if (a.aggressor_price != e.aggressor_price) begin
            $error("aggressor_price exp %0d got %0d", e.aggressor_price, a.aggressor_price);
            errors++;
         end
         if (a.resting_price != e.resting_price) begin
            $error("resting_price exp %0d got %0d", e.resting_price, a.resting_price);
            errors++;
         end
         if (a.trade_quantity != e.trade_quantity) begin
            $error("trade_quantity exp %0d got %0d", e.trade_quantity, a.trade_quantity);
            errors++;
         end
         if (a.last_result != e.last_result) begin
            $error("last_result exp %0d got %0d", e.last_result, a.last_result); errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   book_scoreboard book;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  recv_hold;
   int  idle_cycles = 0;
   int  n_requests;
   bit  timed_out = 1'b0;
   bit [31:0] used_ids[$];

   price_time_order_matcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Note accepted requests, check accepted results, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) book.note_request(req_data);
         if (rsp_valid && rsp_ready) book.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset || recv_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one request and hold it until taken
   task automatic send_request(req_type r);
      do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_requests++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (book.pending.size() != 0) @(negedge clock);
   endtask

   function automatic req_type make_req(mode_type m, bit [31:0] id, bit [15:0] tr, bit s,
                                        order_kind_type t, stp_type st, int p, bit [31:0] q);
      req_type r;
      r.mode = m; r.order_id = id; r.trader_id = tr; r.side = s;
      r.order_type = t; r.stp_action = st; r.price = p; r.quantity = q;
      return r;
   endfunction

   // Random request: mostly adds in a narrow price band, some on already used ids
   function automatic req_type rand_req();
      req_type   r;
      int        pick;
      bit [31:0] id;
      pick = $urandom_range(99);
      if (used_ids.size() != 0 && pick < 35) id = used_ids[$urandom_range(used_ids.size() - 1)];
      else begin
         id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(400);
         used_ids.insert(used_ids.size(), id);
      end
      r.order_id   = id;
      r.trader_id  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      r.side       = 1'($urandom_range(1));
      r.order_type = order_kind_type'($urandom_range(3));
      r.stp_action = stp_type'($urandom_range(3));
      r.price      = ($urandom_range(19) == 0) ? int'($urandom) : 100 + $urandom_range(8) - 4;
      r.quantity   = ($urandom_range(19) == 0) ? $urandom : $urandom_range(50);
      pick = $urandom_range(99);
      if (pick < 60) r.mode = MODE_ADD;
      else if (pick < 78) r.mode = MODE_CANCEL;
      else if (pick < 97) r.mode = MODE_MODIFY;
      else r.mode = MODE_UNUSED;
      if (r.mode != MODE_ADD && pick % 2 == 0 && r.price != 100) r.price = 100;
      return r;
   endfunction

   initial begin
      book = new();
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      send_idle_pct = 17; recv_idle_pct = 55; recv_hold = 0;
      n_requests = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: rests, trades, each order type, self-trade actions, extremes
      send_request(make_req(MODE_ADD, 32'd1, 16'd1, 1'b1, OT_GTC, STP_NONE, 100, 10));
      send_request(make_req(MODE_ADD, 32'd2, 16'd2, 1'b1, OT_GTC, STP_NONE, 101, 10));
      send_request(make_req(MODE_ADD, 32'd1, 16'd1, 1'b0, OT_GTC, STP_NONE, 90, 5));
      send_request(make_req(MODE_ADD, 32'd3, 16'd3, 1'b0, OT_FOK, STP_NONE, 101, 50));
      send_request(make_req(MODE_ADD, 32'd4, 16'd3, 1'b0, OT_FAK, STP_NONE, 50, 5));
      send_request(make_req(MODE_ADD, 32'd5, 16'd3, 1'b0, OT_FOK, STP_NONE, 50, 0));
      send_request(make_req(MODE_ADD, 32'd6, 16'd3, 1'b0, OT_GTC, STP_NONE, 100, 0));
      send_request(make_req(MODE_ADD, 32'd7, 16'd3, 1'b0, OT_FAK, STP_NONE, 101, 12));
      send_request(make_req(MODE_ADD, 32'd8, 16'd2, 1'b0, OT_GTC, STP_CANCEL_AGG, 101, 3));
      send_request(make_req(MODE_ADD, 32'd9, 16'd4, 1'b1, OT_GTC, STP_NONE, 102, 4));
      send_request(make_req(MODE_ADD, 32'd10, 16'd2, 1'b0, OT_MARKET, STP_CANCEL_PAS,
                            32'sh8000_0000, 9));
      send_request(make_req(MODE_ADD, 32'd11, 16'd5, 1'b1, OT_GTC, STP_NONE, 100, 6));
      send_request(make_req(MODE_ADD, 32'd12, 16'd5, 1'b0, OT_GTC, STP_CANCEL_BOTH, 100, 2));
      send_request(make_req(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, OT_GTC, STP_NONE,
                            32'sh7FFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(MODE_MODIFY, 32'hFFFF_FFFF, 16'd0, 1'b1, OT_GTC, STP_NONE,
                            32'sh7FFF_FFFF, 7));
      send_request(make_req(MODE_MODIFY, 32'hFFFF_FFFF, 16'd0, 1'b1, OT_GTC, STP_NONE,
                            200, 7));
      send_request(make_req(MODE_MODIFY, 32'd8, 16'd0, 1'b0, OT_GTC, STP_NONE, 90, 0));
      send_request(make_req(MODE_MODIFY, 32'd77, 16'd0, 1'b0, OT_GTC, STP_NONE, 0, 1));
      send_request(make_req(MODE_CANCEL, 32'd1, 16'd0, 1'b0, OT_GTC, STP_NONE, 0, 0));
      send_request(make_req(MODE_CANCEL, 32'd1, 16'd0, 1'b0, OT_GTC, STP_NONE, 0, 0));
      send_request(make_req(MODE_UNUSED, 32'd5, 16'd0, 1'b0, OT_GTC, STP_NONE, 0, 0));
      // Fill the book to exercise the book-full case
      for (int i = 0; i < NSLOT + 1; i++)
         send_request(make_req(MODE_ADD, 32'd1000 + i, 16'd9, 1'b1, OT_GTC, STP_NONE,
                               1000 + i, 1));
      // Sweep the full book with one market buy
      send_request(make_req(MODE_ADD, 32'd2000, 16'd8, 1'b0, OT_MARKET, STP_NONE, 0, 40));

      // Sender pauses until the block has delivered everything
      wait_drained();

      // Receiver holds off for a long stretch while requests keep coming
      fork
         begin
            recv_hold = 1;
            repeat (400) @(negedge clock);
            recv_hold = 0;
         end
         for (int i = 0; i < 10; i++) send_request(rand_req());
      join

      // Random phases: sender idles less, then receiver less, then neither
      for (int i = 0; i < 155; i++) begin
         if (i == 52) begin send_idle_pct = 55; recv_idle_pct = 17; end
         if (i == 104) begin send_idle_pct = 0; recv_idle_pct = 0; end
         send_request(rand_req());
      end

      wait_drained();
      repeat (300) @(negedge clock);
      $display("Sent %0d requests; checked %0d results including %0d trades.",
               n_requests, book.n_results, book.n_trades);
      $display("Covered all order types, self-trade actions, modify, cancel and book full.");
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/pto_pkg.sv
design/pto_ctrl.sv
design/pto_datapath.sv
design/price_time_order_matcher.sv
tb/sv/testbench.sv
